/* src/pcmot_pkg.sv */
// ----------------------------------------------------------------------------
// pcmot_pkg
// Shared types and constants of the phase current monitor with overcurrent trip
// ----------------------------------------------------------------------------
package pcmot_pkg;

	localparam int RAW_W      = 16;
	localparam int THR_W      = 12;
	localparam int GAIN_W     = 24;
	localparam int WLEN_W     = 16;
	localparam int CFG_W      = 24;
	localparam int CFG_IDX_W  = 2;
	localparam int OUT_W      = 32;
	localparam int RMS_W      = 12;
	localparam int OFS_W      = 14;
	localparam int PEAK_W     = 28;
	localparam int Y_FULL_W   = PEAK_W + 10;
	localparam int PY_SHIFT   = 16;
	localparam int PY_W       = Y_FULL_W - PY_SHIFT;

	// code to millivolts: x*305/2000 as (x*MV_RECIP) >> MV_SHIFT
	localparam int MV_RECIP_W = 23;
	localparam logic [MV_RECIP_W-1:0] MV_RECIP = 23'd5117051;
	localparam int MV_SHIFT   = 25;

	localparam int OFS_MAX    = 8191;
	localparam int OFS_MIN    = -8192;

	// 0.4 in q16
	localparam int PEAK_GAIN_W = 15;
	localparam logic [PEAK_GAIN_W-1:0] PEAK_GAIN = 15'd26214;
	localparam logic [PEAK_W-1:0]      PEAK_MAX  = 28'hFFFFFFF;
	localparam logic [9:0]             Y_SCALE   = 10'd1000;

	// divide by 1414 as (y*RMS_RECIP) >> RMS_SHIFT
	localparam int RMS_RECIP_W = 24;
	localparam logic [RMS_RECIP_W-1:0] RMS_RECIP = 24'd12149837;
	localparam int RMS_SHIFT   = 34;

	localparam logic [RMS_W-1:0]  RMS_LIMIT   = 12'd100;
	localparam logic [THR_W-1:0]  THR_RESET   = 12'd100;
	localparam logic [GAIN_W-1:0] GAIN_RESET  = 24'd67109;
	localparam logic [WLEN_W-1:0] WLEN_RESET  = 16'd400;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_TRIP_THRESHOLD = 2'd0,
		REG_PER_UNIT_GAIN  = 2'd1,
		REG_WINDOW_LENGTH  = 2'd2
	} cfg_reg_t;

	typedef struct packed {
		logic signed [RAW_W-1:0] sample_a;
		logic signed [RAW_W-1:0] sample_c;
		logic                    motor_running;
	} in_item_t;

	typedef struct packed {
		logic signed [OUT_W-1:0] current_a_pu;
		logic signed [OUT_W-1:0] current_b_pu;
		logic signed [OUT_W-1:0] current_c_pu;
		logic                    window_done;
		logic [RMS_W-1:0]        rms_a;
		logic [RMS_W-1:0]        rms_c;
		logic                    fault;
		logic                    stop_request;
	} out_item_t;

	typedef struct packed {
		logic load;
		logic fire;
	} stage_ctl_t;

endpackage

/* src/pcmot_if.sv */
// ----------------------------------------------------------------------------
// pcmot_in_if / pcmot_out_if
// Valid/ready channels for sample pairs and monitor results
// ----------------------------------------------------------------------------
interface pcmot_in_if import pcmot_pkg::*; ();
	logic     valid;
	logic     ready;
	in_item_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface pcmot_out_if import pcmot_pkg::*; ();
	logic      valid;
	logic      ready;
	out_item_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

/* src/phase_current_monitor_overcurrent_trip.sv */
// ----------------------------------------------------------------------------
// phase_current_monitor_overcurrent_trip
// Phase current scaling, zero offset capture and windowed overcurrent trip
// ----------------------------------------------------------------------------
// usage
//   samples: one transfer per converter sample pair (codes of phases a and c
//   plus the running flag); motor_running low captures the zero offsets
//   results: one transfer per sample, carrying per-unit currents of all three
//   phases, the window flag, the latest rms estimates, the fault flag and a
//   one-result stop request
//   cfg_we / cfg_index / cfg_wdata: write threshold, per-unit gain and window
//   length while no sample is in flight
// timing
//   five-stage pipeline (input, millivolt, per-unit product, peak window,
//   rms divide); one sample pair per cycle is sustained while results.ready
//   is high
// reset
//   configuration returns to threshold 100, gain 67109, window 400; offsets,
//   peaks, window count, rms values and fault clear; the pipeline empties
// stall
//   the result register holds while results.ready is low; empty stages keep
//   filling, and samples.ready drops only once every stage holds a sample
// ----------------------------------------------------------------------------
module phase_current_monitor_overcurrent_trip import pcmot_pkg::*; #(
	parameter int SAMPLE_BITS = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	pcmot_in_if.sink             samples,
	pcmot_out_if.source          results,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_wdata
);
	localparam int CW  = SAMPLE_BITS;
	localparam int MVW = SAMPLE_BITS - 2;
	localparam int EW  = (MVW > OFS_W) ? MVW : OFS_W;
	localparam int PUW = EW + 1 + GAIN_W + 1;

	logic [THR_W-1:0]  thr_q;
	logic [GAIN_W-1:0] gain_q;
	logic [WLEN_W-1:0] wlen_q;

	logic v1_q, v2_q, v3_q, v4_q, v5_q;
	logic en1, en2, en3, en4, en5;
	stage_ctl_t ctl3, ctl4, ctl5;

	logic [CW-1:0] code_a_s1;
	logic [CW-1:0] code_c_s1;
	logic          running_s1;
	logic          running_s2;

	logic signed [MVW-1:0] mv_a_s2;
	logic signed [MVW-1:0] mv_c_s2;
	logic signed [PUW-1:0] pu_a_s3;
	logic signed [PUW-1:0] pu_c_s3;
	logic [PEAK_W-1:0]     mag_a_s3;
	logic [PEAK_W-1:0]     mag_c_s3;
	logic signed [OUT_W-1:0] cur_a_s4;
	logic signed [OUT_W-1:0] cur_b_s4;
	logic signed [OUT_W-1:0] cur_c_s4;
	logic                  done_s4;
	logic [PY_W-1:0]       peak_a_s4;
	logic [PY_W-1:0]       peak_c_s4;
	out_item_t             result_q;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q  <= THR_RESET;
			gain_q <= GAIN_RESET;
			wlen_q <= WLEN_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_TRIP_THRESHOLD: thr_q  <= cfg_wdata[THR_W-1:0];
				REG_PER_UNIT_GAIN:  gain_q <= cfg_wdata[GAIN_W-1:0];
				REG_WINDOW_LENGTH:  wlen_q <= cfg_wdata[WLEN_W-1:0];
				default: ;
			endcase
		end
	end

	// stage enables, bubbles collapse towards the result register
	always_comb begin
		en5 = !v5_q || results.ready;
		en4 = !v4_q || en5;
		en3 = !v3_q || en4;
		en2 = !v2_q || en3;
		en1 = !v1_q || en2;
		ctl3 = '{load: en3, fire: en3 && v2_q};
		ctl4 = '{load: en4, fire: en4 && v3_q};
		ctl5 = '{load: en5, fire: en5 && v4_q};
	end

	assign samples.ready = en1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v1_q <= 1'b0;
			v2_q <= 1'b0;
			v3_q <= 1'b0;
			v4_q <= 1'b0;
			v5_q <= 1'b0;
		end else begin
			if (en1) v1_q <= samples.valid;
			if (en2) v2_q <= v1_q;
			if (en3) v3_q <= v2_q;
			if (en4) v4_q <= v3_q;
			if (en5) v5_q <= v4_q;
		end
	end

	always_ff @(posedge clk) begin
		if (en1) begin
			code_a_s1  <= CW'($unsigned(samples.data.sample_a));
			code_c_s1  <= CW'($unsigned(samples.data.sample_c));
			running_s1 <= samples.data.motor_running;
		end
		if (en2) begin
			running_s2 <= running_s1;
		end
	end

	pcmot_scale #(.SAMPLE_BITS(SAMPLE_BITS)) u_scale_a (
		.clk   (clk),
		.load  (en2),
		.code  (code_a_s1),
		.mv_s2 (mv_a_s2)
	);

	pcmot_scale #(.SAMPLE_BITS(SAMPLE_BITS)) u_scale_c (
		.clk   (clk),
		.load  (en2),
		.code  (code_c_s1),
		.mv_s2 (mv_c_s2)
	);

	pcmot_phase #(.SAMPLE_BITS(SAMPLE_BITS)) u_phase_a (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctl     (ctl3),
		.running (running_s2),
		.mv      (mv_a_s2),
		.gain    (gain_q),
		.pu_s3   (pu_a_s3),
		.mag_s3  (mag_a_s3)
	);

	pcmot_phase #(.SAMPLE_BITS(SAMPLE_BITS)) u_phase_c (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctl     (ctl3),
		.running (running_s2),
		.mv      (mv_c_s2),
		.gain    (gain_q),
		.pu_s3   (pu_c_s3),
		.mag_s3  (mag_c_s3)
	);

	pcmot_window #(.SAMPLE_BITS(SAMPLE_BITS)) u_window (
		.clk           (clk),
		.arst_n        (arst_n),
		.ctl           (ctl4),
		.pu_a          (pu_a_s3),
		.pu_c          (pu_c_s3),
		.mag_a         (mag_a_s3),
		.mag_c         (mag_c_s3),
		.window_length (wlen_q),
		.cur_a_s4      (cur_a_s4),
		.cur_b_s4      (cur_b_s4),
		.cur_c_s4      (cur_c_s4),
		.done_s4       (done_s4),
		.peak_a_s4     (peak_a_s4),
		.peak_c_s4     (peak_c_s4)
	);

	pcmot_trip u_trip (
		.clk            (clk),
		.arst_n         (arst_n),
		.ctl            (ctl5),
		.cur_a          (cur_a_s4),
		.cur_b          (cur_b_s4),
		.cur_c          (cur_c_s4),
		.done           (done_s4),
		.peak_a         (peak_a_s4),
		.peak_c         (peak_c_s4),
		.trip_threshold (thr_q),
		.result_q       (result_q)
	);

	assign results.valid = v5_q;
	assign results.data  = result_q;

`ifndef ASSERT_OFF
	// a stop request only comes with a closed window and a set fault
	assert property (@(posedge clk) disable iff (!arst_n)
		results.valid && results.data.stop_request
		|-> results.data.window_done && results.data.fault)
		else $error("stop request without window close and fault");

	// the fault flag never falls once a result has shown it
	assert property (@(posedge clk) disable iff (!arst_n)
		results.valid && results.data.fault |=> results.data.fault)
		else $error("fault flag cleared without reset");

	// samples are refused only when every stage is occupied
	assert property (@(posedge clk) disable iff (!arst_n)
		!samples.ready |-> v1_q && v2_q && v3_q && v4_q && v5_q)
		else $error("sample refused with an empty stage");
`endif
endmodule

/* src/pcmot_scale.sv */
// ----------------------------------------------------------------------------
// pcmot_scale
// Converter code to millivolts, truncated toward zero, registered
// ----------------------------------------------------------------------------
module pcmot_scale import pcmot_pkg::*; #(
	parameter int SAMPLE_BITS = 16
) (
	input  logic                          clk,
	input  logic                          load,
	input  logic [SAMPLE_BITS-1:0]        code,
	output logic signed [SAMPLE_BITS-3:0] mv_s2
);
	localparam int CW  = SAMPLE_BITS;
	localparam int MVW = SAMPLE_BITS - 2;
	localparam int QW  = MVW - 1;
	localparam int PW  = CW + MV_RECIP_W;

	logic [CW-1:0]         mag;
	logic [PW-1:0]         prod;
	logic [QW-1:0]         q;
	logic signed [MVW-1:0] mv;

	always_comb begin
		mag  = code[CW-1] ? (~code + 1'b1) : code;
		prod = PW'(mag) * PW'(MV_RECIP);
		q    = prod[MV_SHIFT +: QW];
		mv   = code[CW-1] ? -$signed({1'b0, q}) : $signed({1'b0, q});
	end

	always_ff @(posedge clk) begin
		if (load) begin
			mv_s2 <= mv;
		end
	end
endmodule

/* src/pcmot_phase.sv */
// ----------------------------------------------------------------------------
// pcmot_phase
// Zero offset capture, per-unit product and scaled magnitude of one phase
// ----------------------------------------------------------------------------
module pcmot_phase import pcmot_pkg::*; #(
	parameter int SAMPLE_BITS = 16
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  stage_ctl_t             ctl,
	input  logic                   running,
	input  logic signed [SAMPLE_BITS-3:0] mv,
	input  logic [GAIN_W-1:0]      gain,
	output logic signed [((SAMPLE_BITS-2 > OFS_W) ? SAMPLE_BITS-2 : OFS_W) + GAIN_W + 1:0] pu_s3,
	output logic [PEAK_W-1:0]      mag_s3
);
	localparam int MVW = SAMPLE_BITS - 2;
	localparam int EW  = (MVW > OFS_W) ? MVW : OFS_W;
	localparam int DW  = EW + 1;
	localparam int PUW = DW + GAIN_W + 1;
	localparam int MPW = DW + PEAK_GAIN_W;

	logic signed [EW-1:0]    mv_e;
	logic signed [EW-1:0]    clamped;
	logic signed [EW-1:0]    ofs_e;
	logic signed [OFS_W-1:0] ofs_q;
	logic signed [OFS_W-1:0] ofs_next;
	logic signed [DW-1:0]    diff;
	logic [DW-1:0]           absd;
	logic [MPW-1:0]          mprod;
	logic signed [PUW-1:0]   pu;
	logic [PEAK_W-1:0]       mag;

	always_comb begin
		mv_e = EW'(mv);
		if (mv_e > EW'(OFS_MAX)) begin
			clamped = EW'(OFS_MAX);
		end else if (mv_e < EW'(OFS_MIN)) begin
			clamped = EW'(OFS_MIN);
		end else begin
			clamped = mv_e;
		end
		ofs_next = running ? ofs_q : OFS_W'(clamped);
		ofs_e    = EW'(ofs_next);
		diff     = DW'(mv_e) - DW'(ofs_e);
		absd     = diff[DW-1] ? $unsigned(-diff) : $unsigned(diff);
		pu       = PUW'(diff) * PUW'($signed({1'b0, gain}));
		mprod    = MPW'(absd) * MPW'(PEAK_GAIN);
		mag      = (mprod > MPW'(PEAK_MAX)) ? PEAK_MAX : mprod[PEAK_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ofs_q <= '0;
		end else if (ctl.fire) begin
			ofs_q <= ofs_next;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			pu_s3  <= pu;
			mag_s3 <= mag;
		end
	end
endmodule

/* src/pcmot_window.sv */
// ----------------------------------------------------------------------------
// pcmot_window
// Output saturation, phase b, peak tracking and window counting
// ----------------------------------------------------------------------------
module pcmot_window import pcmot_pkg::*; #(
	parameter int SAMPLE_BITS = 16
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  stage_ctl_t              ctl,
	input  logic signed [((SAMPLE_BITS-2 > OFS_W) ? SAMPLE_BITS-2 : OFS_W) + GAIN_W + 1:0] pu_a,
	input  logic signed [((SAMPLE_BITS-2 > OFS_W) ? SAMPLE_BITS-2 : OFS_W) + GAIN_W + 1:0] pu_c,
	input  logic [PEAK_W-1:0]       mag_a,
	input  logic [PEAK_W-1:0]       mag_c,
	input  logic [WLEN_W-1:0]       window_length,
	output logic signed [OUT_W-1:0] cur_a_s4,
	output logic signed [OUT_W-1:0] cur_b_s4,
	output logic signed [OUT_W-1:0] cur_c_s4,
	output logic                    done_s4,
	output logic [PY_W-1:0]         peak_a_s4,
	output logic [PY_W-1:0]         peak_c_s4
);
	localparam int MVW = SAMPLE_BITS - 2;
	localparam int EW  = (MVW > OFS_W) ? MVW : OFS_W;
	localparam int PUW = EW + 1 + GAIN_W + 1;
	localparam int BW  = PUW + 1;
	localparam logic signed [BW-1:0] S_MAX = BW'(64'sd2147483647);
	localparam logic signed [BW-1:0] S_MIN = BW'(-64'sd2147483648);

	function automatic logic signed [OUT_W-1:0] sat_out(input logic signed [BW-1:0] v);
		logic signed [BW-1:0] r;
		if (v > S_MAX) begin
			r = S_MAX;
		end else if (v < S_MIN) begin
			r = S_MIN;
		end else begin
			r = v;
		end
		return r[OUT_W-1:0];
	endfunction

	logic signed [BW-1:0]  pu_b;
	logic [Y_FULL_W-1:0]   ya_full;
	logic [Y_FULL_W-1:0]   yc_full;
	logic [PY_W-1:0]       ya;
	logic [PY_W-1:0]       yc;
	logic [PY_W-1:0]       peak_a_q;
	logic [PY_W-1:0]       peak_c_q;
	logic [PY_W-1:0]       max_a;
	logic [PY_W-1:0]       max_c;
	logic [WLEN_W-1:0]     cnt_q;
	logic [WLEN_W-1:0]     cnt_next;
	logic                  close;

	// peaks are held scaled by 1000/65536, ready for the divide by 1414
	always_comb begin
		pu_b     = -BW'(pu_a) - BW'(pu_c);
		ya_full  = Y_FULL_W'(mag_a) * Y_FULL_W'(Y_SCALE);
		yc_full  = Y_FULL_W'(mag_c) * Y_FULL_W'(Y_SCALE);
		ya       = ya_full[PY_SHIFT +: PY_W];
		yc       = yc_full[PY_SHIFT +: PY_W];
		max_a    = (ya > peak_a_q) ? ya : peak_a_q;
		max_c    = (yc > peak_c_q) ? yc : peak_c_q;
		cnt_next = cnt_q + 1'b1;
		close    = (cnt_next >= window_length);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q    <= '0;
			peak_a_q <= '0;
			peak_c_q <= '0;
		end else if (ctl.fire) begin
			cnt_q    <= close ? '0 : cnt_next;
			peak_a_q <= close ? '0 : max_a;
			peak_c_q <= close ? '0 : max_c;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			cur_a_s4  <= sat_out(BW'(pu_a));
			cur_b_s4  <= sat_out(pu_b);
			cur_c_s4  <= sat_out(BW'(pu_c));
			done_s4   <= close;
			peak_a_s4 <= max_a;
			peak_c_s4 <= max_c;
		end
	end
endmodule

/* src/pcmot_trip.sv */
// ----------------------------------------------------------------------------
// pcmot_trip
// RMS estimate, trip decision, sticky fault and result register
// ----------------------------------------------------------------------------
module pcmot_trip import pcmot_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  stage_ctl_t              ctl,
	input  logic signed [OUT_W-1:0] cur_a,
	input  logic signed [OUT_W-1:0] cur_b,
	input  logic signed [OUT_W-1:0] cur_c,
	input  logic                    done,
	input  logic [PY_W-1:0]         peak_a,
	input  logic [PY_W-1:0]         peak_c,
	input  logic [THR_W-1:0]        trip_threshold,
	output out_item_t               result_q
);
	localparam int RPW = PY_W + RMS_RECIP_W;

	logic [RPW-1:0]   prod_a;
	logic [RPW-1:0]   prod_c;
	logic [RMS_W-1:0] est_a;
	logic [RMS_W-1:0] est_c;
	logic [RMS_W-1:0] last_a_q;
	logic [RMS_W-1:0] last_c_q;
	logic [RMS_W-1:0] rms_a_new;
	logic [RMS_W-1:0] rms_c_new;
	logic             fault_q;
	logic             trip;

	always_comb begin
		prod_a    = RPW'(peak_a) * RPW'(RMS_RECIP);
		prod_c    = RPW'(peak_c) * RPW'(RMS_RECIP);
		est_a     = prod_a[RMS_SHIFT +: RMS_W];
		est_c     = prod_c[RMS_SHIFT +: RMS_W];
		trip      = done && ((est_a > trip_threshold) || (est_c > trip_threshold) ||
			(est_a > RMS_LIMIT) || (est_c > RMS_LIMIT));
		rms_a_new = done ? est_a : last_a_q;
		rms_c_new = done ? est_c : last_c_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_a_q <= '0;
			last_c_q <= '0;
			fault_q  <= 1'b0;
		end else if (ctl.fire) begin
			last_a_q <= rms_a_new;
			last_c_q <= rms_c_new;
			fault_q  <= fault_q | trip;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			result_q.current_a_pu <= cur_a;
			result_q.current_b_pu <= cur_b;
			result_q.current_c_pu <= cur_c;
			result_q.window_done  <= done;
			result_q.rms_a        <= rms_a_new;
			result_q.rms_c        <= rms_c_new;
			result_q.fault        <= fault_q | trip;
			result_q.stop_request <= trip;
		end
	end
endmodule
